@@ src/bounded_shortest_queue_dispatcher_macros.svh @@
// Assertion macros used by the dispatcher datapath.
// Expects signals named clk and arst_n in the including module.
`ifndef BOUNDED_SHORTEST_QUEUE_DISPATCHER_MACROS_SVH
`define BOUNDED_SHORTEST_QUEUE_DISPATCHER_MACROS_SVH

// condition must hold at every edge out of reset
`define BSQD_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// same-cycle implication
`define BSQD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ src/bsqd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the shortest-queue dispatcher.
// No dependencies.
package bsqd_pkg;

	localparam int NUM_WORKERS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int TAG_BITS        = 16;
	localparam int MAX_RESULTS     = 16;

	localparam int CNT_W      = 5;
	localparam int SERVED_W   = 32;
	localparam int BOUND_W    = 4;
	localparam int ACT_W      = 5;
	localparam int FW_W       = 4;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CNT_W-1:0]   COUNT_MAX  = 5'd31;
	localparam logic [ACT_W-1:0]   ACTIVE_RST = 5'd16;
	localparam logic [BOUND_W-1:0] BOUND_RST  = 4'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WORKERS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BOUND  = 1'd1;

	typedef enum logic [2:0] {
		KIND_DISPATCH = 3'd0,
		KIND_QUEUED   = 3'd1,
		KIND_DROPPED  = 3'd2,
		KIND_FB_NONE  = 3'd3,
		KIND_FB_ERROR = 3'd4
	} kind_t;

	typedef struct packed {
		logic                mode;
		logic [TAG_BITS-1:0] request_tag;
		logic [FW_W-1:0]     feedback_worker;
		logic [SERVED_W-1:0] served_total;
		logic [BOUND_W-1:0]  new_bound;
	} in_word_t;

	typedef struct packed {
		kind_t               kind;
		logic [TAG_BITS-1:0] dispatch_tag;
		logic [FW_W-1:0]     dest_worker;
		logic                last;
	} out_word_t;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_CAPTURE,
		DP_REQ,
		DP_FB_CALC,
		DP_FB_APPLY,
		DP_FB_ERROR,
		DP_DRAIN,
		DP_DRAIN_END
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic new_is_fb;
		logic sel_valid;
		logic fifo_empty;
		logic drain_full;
		logic fb_err;
		logic pend_valid;
		logic out_free;
	} dp_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REQ_PICK,
		ST_REQ_DONE,
		ST_FB_CALC,
		ST_FB_APPLY,
		ST_DRAIN_PICK,
		ST_DRAIN_STEP,
		ST_DRAIN_END
	} state_t;

endpackage

@@ src/bounded_shortest_queue_dispatcher.sv @@
`timescale 1ns / 1ps
// Join-bounded-shortest-queue dispatcher. One word is handled at a time. Worker
// selection goes through a registered minimum tree of log2(NUM_WORKERS) stages
// (L = 4 at sixteen workers), and every pick waits for that tree to settle. A
// feedback word is checked and applied, then makes one pick for each tag drained
// and one more that ends the drain, before its final result; a rejected feedback
// word gives an error result after the check. Output stall can hold a result
// back. A finished result waits in an output register, so the next word can be
// accepted while it is held.
// Depends on bsqd_pkg, bsqd_ctrl and bsqd_datapath.
module bounded_shortest_queue_dispatcher import bsqd_pkg::*; #(
	parameter int NUM_WORKERS = NUM_WORKERS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_word_t              in_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_word
);

	dp_cmd_t    cmd;
	dp_status_t status;

	bsqd_ctrl #(
		.NUM_WORKERS(NUM_WORKERS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	bsqd_datapath #(
		.NUM_WORKERS(NUM_WORKERS),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_word  (in_word),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_word (out_word),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

@@ src/bsqd_min_tree.sv @@
`timescale 1ns / 1ps
// Registered minimum tree selecting the least-loaded worker with room.
// Depends on bsqd_pkg. Each level of the tree is registered.
module bsqd_min_tree import bsqd_pkg::*; #(
	parameter int NUM_WORKERS = NUM_WORKERS_DEF,
	localparam int WIDX = $clog2(NUM_WORKERS)
) (
	input  logic                                  clk,
	input  logic [NUM_WORKERS-1:0][CNT_W-1:0]     counts,
	input  logic [NUM_WORKERS-1:0][BOUND_W-1:0]   bounds,
	input  logic [ACT_W-1:0]                      active,
	output logic                                  sel_valid,
	output logic [WIDX-1:0]                       sel_idx,
	output logic [CNT_W-1:0]                      sel_count
);

	localparam int LEAVES = 1 << WIDX;
	localparam int KEY_W  = 1 + CNT_W + WIDX;

	// key = {no room, count, index}: the smallest key is the winner
	logic [KEY_W-1:0] leaf_key [LEAVES];
	logic [KEY_W-1:0] node_q [1:LEAVES-1];

	for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
		if (i < NUM_WORKERS) begin : g_real
			assign leaf_key[i] = {~((32'(i) < 32'(active)) &&
				(counts[i] < CNT_W'(bounds[i]))), counts[i], WIDX'(i)};
		end else begin : g_pad
			assign leaf_key[i] = {1'b1, {CNT_W{1'b0}}, WIDX'(i)};
		end
	end

	for (genvar j = 1; j < LEAVES; j++) begin : g_node
		logic [KEY_W-1:0] a, b;
		if (2 * j >= LEAVES) begin : g_from_leaf
			assign a = leaf_key[2 * j - LEAVES];
			assign b = leaf_key[2 * j + 1 - LEAVES];
		end else begin : g_from_node
			assign a = node_q[2 * j];
			assign b = node_q[2 * j + 1];
		end
		always_ff @(posedge clk) begin
			node_q[j] <= (b < a) ? b : a;
		end
	end

	assign sel_valid = ~node_q[1][KEY_W-1];
	assign sel_count = node_q[1][KEY_W-2 -: CNT_W];
	assign sel_idx   = node_q[1][WIDX-1:0];

endmodule

@@ src/bsqd_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: worker tables, tag FIFO, feedback arithmetic and output register.
// Depends on bsqd_pkg, bsqd_min_tree and the dispatcher assertion macros.
`include "bounded_shortest_queue_dispatcher_macros.svh"
module bsqd_datapath import bsqd_pkg::*; #(
	parameter int NUM_WORKERS = NUM_WORKERS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_word_t              in_word,
	input  logic                  out_stall,
	output logic                  out_valid,
	output out_word_t             out_word,
	input  dp_cmd_t               cmd,
	output dp_status_t            status
);

	localparam int WIDX   = $clog2(NUM_WORKERS);
	localparam int QW     = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int DRN_W  = $clog2(MAX_RESULTS + 1);
	localparam int DIFF_W = SERVED_W + 2;

	logic [ACT_W-1:0]                     active_q;
	logic [NUM_WORKERS-1:0][CNT_W-1:0]    count_q;
	logic [NUM_WORKERS-1:0][SERVED_W-1:0] served_q;
	logic [NUM_WORKERS-1:0][BOUND_W-1:0]  bound_q;
	in_word_t                             in_q;

	logic [TAG_BITS-1:0] mem [QUEUE_DEPTH];
	logic [TAG_BITS-1:0] rd_tag_q;
	logic [QW-1:0]       head_q, tail_q;
	logic [FILL_W-1:0]   fill_q;

	logic               fb_err_q;
	logic [CNT_W-1:0]   nc_q;
	logic               pend_valid_q;
	logic [TAG_BITS-1:0] pend_tag_q;
	logic [FW_W-1:0]    pend_worker_q;
	logic [DRN_W-1:0]   drained_q;
	logic               out_valid_q;
	out_word_t          out_q;

	logic             sel_valid;
	logic [WIDX-1:0]  sel_idx;
	logic [CNT_W-1:0] sel_count;
	logic [CNT_W-1:0] sel_inc;
	logic             dispatch, push, pop, fifo_full;
	logic [WIDX-1:0]  fw_idx;
	logic             fw_ok;
	logic [DIFF_W-1:0] diff;
	logic             out_load;
	out_word_t        out_next;

	bsqd_min_tree #(
		.NUM_WORKERS(NUM_WORKERS)
	) u_tree (
		.clk      (clk),
		.counts   (count_q),
		.bounds   (bound_q),
		.active   (active_q),
		.sel_valid(sel_valid),
		.sel_idx  (sel_idx),
		.sel_count(sel_count)
	);

	assign fifo_full = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign dispatch  = ((cmd.op == DP_REQ) || (cmd.op == DP_DRAIN)) && sel_valid;
	assign push      = (cmd.op == DP_REQ) && !sel_valid && !fifo_full;
	assign pop       = (cmd.op == DP_DRAIN);
	assign sel_inc   = (sel_count == COUNT_MAX) ? sel_count : sel_count + CNT_W'(1);

	assign fw_idx = WIDX'(in_q.feedback_worker);
	assign fw_ok  = (32'(in_q.feedback_worker) < 32'(active_q)) &&
		(32'(in_q.feedback_worker) < NUM_WORKERS);
	assign diff   = DIFF_W'(served_q[fw_idx]) + DIFF_W'(count_q[fw_idx]) -
		DIFF_W'(in_q.served_total);

	// configuration and worker tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RST;
			for (int i = 0; i < NUM_WORKERS; i++) begin
				count_q[i]  <= '0;
				served_q[i] <= '0;
				bound_q[i]  <= BOUND_RST;
			end
		end else begin
			if (cfg_write && (cfg_index == REG_ACTIVE_WORKERS)) begin
				active_q <= cfg_data[ACT_W-1:0];
			end
			for (int i = 0; i < NUM_WORKERS; i++) begin
				if (cfg_write && (cfg_index == REG_INITIAL_BOUND)) begin
					bound_q[i] <= cfg_data[BOUND_W-1:0];
				end
				if ((cmd.op == DP_FB_APPLY) && (fw_idx == WIDX'(i))) begin
					count_q[i]  <= nc_q;
					served_q[i] <= in_q.served_total;
					bound_q[i]  <= in_q.new_bound;
				end
				if (dispatch && (sel_idx == WIDX'(i))) begin
					count_q[i] <= sel_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_CAPTURE) begin
			in_q <= in_word;
		end
		if (cmd.op == DP_FB_CALC) begin
			nc_q <= (|diff[SERVED_W:CNT_W]) ? COUNT_MAX : diff[CNT_W-1:0];
		end
		if (pop) begin
			pend_tag_q    <= rd_tag_q;
			pend_worker_q <= FW_W'(sel_idx);
		end
		if (out_load) begin
			out_q <= out_next;
		end
	end

	// tag FIFO storage, registered read of the head entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= in_q.request_tag;
		end
		rd_tag_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			fill_q       <= '0;
			fb_err_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			drained_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QW'(1);
				fill_q <= fill_q + FILL_W'(1);
			end
			if (pop) begin
				head_q       <= (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QW'(1);
				fill_q       <= fill_q - FILL_W'(1);
				pend_valid_q <= 1'b1;
				drained_q    <= drained_q + DRN_W'(1);
			end
			if (cmd.op == DP_FB_CALC) begin
				fb_err_q <= !fw_ok || diff[DIFF_W-1];
			end
			if (cmd.op == DP_FB_APPLY) begin
				pend_valid_q <= 1'b0;
				drained_q    <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		out_load = 1'b0;
		out_next = '{kind: KIND_FB_NONE, dispatch_tag: '0, dest_worker: '0, last: 1'b1};
		unique case (cmd.op)
			DP_REQ: begin
				out_load = 1'b1;
				if (sel_valid) begin
					out_next.kind         = KIND_DISPATCH;
					out_next.dispatch_tag = in_q.request_tag;
					out_next.dest_worker  = FW_W'(sel_idx);
				end else if (fifo_full) begin
					out_next.kind = KIND_DROPPED;
				end else begin
					out_next.kind = KIND_QUEUED;
				end
			end
			DP_FB_ERROR: begin
				out_load      = 1'b1;
				out_next.kind = KIND_FB_ERROR;
			end
			DP_DRAIN, DP_DRAIN_END: begin
				out_load = (cmd.op == DP_DRAIN_END) || pend_valid_q;
				if (pend_valid_q) begin
					out_next.kind         = KIND_DISPATCH;
					out_next.dispatch_tag = pend_tag_q;
					out_next.dest_worker  = pend_worker_q;
					out_next.last         = (cmd.op == DP_DRAIN_END);
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	assign status.new_is_fb  = in_word.mode;
	assign status.sel_valid  = sel_valid;
	assign status.fifo_empty = (fill_q == '0);
	assign status.drain_full = (drained_q == DRN_W'(MAX_RESULTS));
	assign status.fb_err     = fb_err_q;
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = !out_valid_q || !out_stall;

	`BSQD_ASSERT_HOLDS(a_fill_range, fill_q <= FILL_W'(QUEUE_DEPTH), "fifo fill above depth")
	`BSQD_ASSERT_IMPL(a_ptr_meet, (fill_q == '0) || fifo_full, head_q == tail_q, "pointer mismatch")
	`BSQD_ASSERT_IMPL(a_pop_ok, pop, (fill_q != '0) && sel_valid, "pop without tag or worker")
	`BSQD_ASSERT_IMPL(a_pick_stale, dispatch, sel_count == count_q[sel_idx], "stale worker picked")
	`BSQD_ASSERT_IMPL(a_pick_room, dispatch, sel_count < CNT_W'(bound_q[sel_idx]), "no room")

endmodule

@@ src/bsqd_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: sequences request, feedback and drain steps.
// Depends on bsqd_pkg; drives the datapath through dp_cmd_t.
module bsqd_ctrl import bsqd_pkg::*; #(
	parameter int NUM_WORKERS = NUM_WORKERS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam int LVLS   = $clog2(NUM_WORKERS);
	localparam int WAIT_W = $clog2(LVLS + 1);

	state_t            state_q, state_d;
	logic [WAIT_W-1:0] wait_q;
	logic              wait_done;
	logic              picking;
	logic              stop;

	assign picking   = (state_q == ST_REQ_PICK) || (state_q == ST_DRAIN_PICK);
	assign wait_done = (wait_q == WAIT_W'(LVLS - 1));
	assign stop      = status.drain_full || status.fifo_empty || !status.sel_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q  <= '0;
		end else begin
			state_q <= state_d;
			wait_q  <= (picking && !wait_done) ? wait_q + WAIT_W'(1) : '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = status.new_is_fb ? ST_FB_CALC : ST_REQ_PICK;
				end
			end
			ST_REQ_PICK: begin
				if (wait_done) begin
					state_d = ST_REQ_DONE;
				end
			end
			ST_REQ_DONE: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_FB_CALC: begin
				state_d = ST_FB_APPLY;
			end
			ST_FB_APPLY: begin
				if (!status.fb_err) begin
					state_d = ST_DRAIN_PICK;
				end else if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DRAIN_PICK: begin
				if (wait_done) begin
					state_d = ST_DRAIN_STEP;
				end
			end
			ST_DRAIN_STEP: begin
				if (stop) begin
					state_d = ST_DRAIN_END;
				end else if (!status.pend_valid || status.out_free) begin
					state_d = ST_DRAIN_PICK;
				end
			end
			ST_DRAIN_END: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.op   = DP_NOP;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = DP_CAPTURE;
				end
			end
			ST_REQ_DONE: begin
				if (status.out_free) begin
					cmd.op = DP_REQ;
				end
			end
			ST_FB_CALC: begin
				cmd.op = DP_FB_CALC;
			end
			ST_FB_APPLY: begin
				if (!status.fb_err) begin
					cmd.op = DP_FB_APPLY;
				end else if (status.out_free) begin
					cmd.op = DP_FB_ERROR;
				end
			end
			ST_DRAIN_STEP: begin
				if (!stop && (!status.pend_valid || status.out_free)) begin
					cmd.op = DP_DRAIN;
				end
			end
			ST_DRAIN_END: begin
				if (status.out_free) begin
					cmd.op = DP_DRAIN_END;
				end
			end
			default: begin
				cmd.op = DP_NOP;
			end
		endcase
	end

endmodule

@@ tb/tb_bounded_shortest_queue_dispatcher.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the shortest-queue dispatcher: a directed opener, then
// random phases under several worker counts and bounds, all checked against a predictor.
// Depends on bsqd_pkg and bounded_shortest_queue_dispatcher.
module tb_bounded_shortest_queue_dispatcher;
	import bsqd_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_word_t              in_word = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_word_t             out_word;

	bounded_shortest_queue_dispatcher uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	always #5 clk = ~clk;

	// shadow of the dispatcher state
	logic [ACT_W-1:0]    act_cfg = ACTIVE_RST;
	logic [BOUND_W-1:0]  wk_count_init = BOUND_RST;
	logic [CNT_W-1:0]    wk_count [NUM_WORKERS_DEF];
	logic [SERVED_W-1:0] wk_served [NUM_WORKERS_DEF];
	logic [BOUND_W-1:0]  wk_bound [NUM_WORKERS_DEF];
	logic [TAG_BITS-1:0] tag_fifo [$];

	in_word_t  send_q [$];
	out_word_t due_results [$];
	logic      in_taken = 1'b0;
	int        idle_pct = 7;
	int        err_count = 0;
	int        quiet_cycles = 0;

	initial begin
		for (int i = 0; i < NUM_WORKERS_DEF; i++) begin
			wk_count[i] = '0;
			wk_served[i] = '0;
			wk_bound[i] = BOUND_RST;
		end
	end

	function automatic int active_slots();
		return (act_cfg > NUM_WORKERS_DEF) ? NUM_WORKERS_DEF : int'(act_cfg);
	endfunction

	function automatic int pick_worker();
		int         sel;
		logic [5:0] best;
		sel = -1;
		best = 6'd32;
		for (int i = 0; i < active_slots(); i++) begin
			if (wk_count[i] < best && wk_count[i] < wk_bound[i]) begin
				best = {1'b0, wk_count[i]};
				sel = i;
			end
		end
		return sel;
	endfunction

	function automatic void charge_worker(int w);
		if (wk_count[w] < COUNT_MAX)
			wk_count[w] = wk_count[w] + 1'b1;
	endfunction

	task automatic take_word(input in_word_t w);
		out_word_t          r;
		out_word_t          held;
		logic               have_held;
		int                 sel;
		int                 drained;
		logic [FW_W-1:0]    fw;
		logic signed [34:0] nc;
		r = '0;
		r.last = 1'b1;
		held = '0;
		have_held = 1'b0;
		fw = w.feedback_worker;
		if (w.mode == 1'b0) begin
			sel = pick_worker();
			if (sel >= 0) begin
				charge_worker(sel);
				r.kind = KIND_DISPATCH;
				r.dispatch_tag = w.request_tag;
				r.dest_worker = sel[FW_W-1:0];
			end else if (tag_fifo.size() < QUEUE_DEPTH_DEF) begin
				tag_fifo.insert(tag_fifo.size(), w.request_tag);
				r.kind = KIND_QUEUED;
			end else begin
				r.kind = KIND_DROPPED;
			end
			due_results.insert(due_results.size(), r);
		end else begin
			nc = $signed({30'd0, wk_count[fw]}) + $signed({3'd0, wk_served[fw]})
				- $signed({3'd0, w.served_total});
			if (fw >= active_slots() || nc < 0) begin
				r.kind = KIND_FB_ERROR;
				due_results.insert(due_results.size(), r);
			end else begin
				wk_served[fw] = w.served_total;
				wk_bound[fw] = w.new_bound;
				wk_count[fw] = (nc > 35'sd31) ? COUNT_MAX : nc[CNT_W-1:0];
				drained = 0;
				while (drained < MAX_RESULTS && tag_fifo.size() != 0) begin
					sel = pick_worker();
					if (sel < 0)
						break;
					if (have_held)
						due_results.insert(due_results.size(), held);
					held = '0;
					held.kind = KIND_DISPATCH;
					held.dispatch_tag = tag_fifo.pop_front();
					held.dest_worker = sel[FW_W-1:0];
					charge_worker(sel);
					have_held = 1'b1;
					drained++;
				end
				if (have_held) begin
					held.last = 1'b1;
					due_results.insert(due_results.size(), held);
				end else begin
					r.kind = KIND_FB_NONE;
					due_results.insert(due_results.size(), r);
				end
			end
		end
	endtask

	// mostly well-formed feedback built from the current shadow, the rest noise
	function automatic in_word_t draw_word(int req_pct);
		in_word_t    w;
		logic [31:0] rnd;
		int          n;
		int          fw;
		int          cut;
		rnd = $urandom;
		w.request_tag = rnd[TAG_BITS-1:0];
		rnd = $urandom;
		w.feedback_worker = rnd[FW_W-1:0];
		w.new_bound = rnd[FW_W+BOUND_W-1:FW_W];
		w.served_total = $urandom;
		w.mode = ($urandom_range(99) < req_pct) ? 1'b0 : 1'b1;
		n = active_slots();
		if (w.mode && n > 0 && $urandom_range(99) < 80) begin
			fw = $urandom_range(n - 1);
			w.feedback_worker = fw[FW_W-1:0];
			if ($urandom_range(3) == 0) begin
				cut = $urandom_range((wk_served[fw] < 20) ? int'(wk_served[fw]) : 20);
				w.served_total = wk_served[fw] - cut;
			end else begin
				w.served_total = wk_served[fw] + $urandom_range(wk_count[fw]);
			end
		end else if (w.mode && $urandom_range(1) == 0) begin
			w.served_total = $urandom_range(40);
		end
		return w;
	endfunction

	function automatic in_word_t word_of(logic mode, logic [TAG_BITS-1:0] tag,
			logic [FW_W-1:0] fw, logic [SERVED_W-1:0] st, logic [BOUND_W-1:0] nb);
		in_word_t w;
		w.mode = mode;
		w.request_tag = tag;
		w.feedback_worker = fw;
		w.served_total = st;
		w.new_bound = nb;
		return w;
	endfunction

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (send_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				in_valid <= 1'b1;
				in_word <= send_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < idle_pct);
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		in_taken = in_valid && !in_stall;
		if (cfg_write) begin
			case (cfg_index)
				REG_ACTIVE_WORKERS: act_cfg = cfg_data[ACT_W-1:0];
				REG_INITIAL_BOUND: begin
					wk_count_init = cfg_data[BOUND_W-1:0];
					for (int i = 0; i < NUM_WORKERS_DEF; i++)
						wk_bound[i] = wk_count_init;
				end
				default: ;
			endcase
		end
		if (arst_n) begin
			if (in_valid && !in_stall)
				take_word(in_word);
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("unexpected word: kind=%0d tag=%h worker=%0d last=%b",
							out_word.kind, out_word.dispatch_tag, out_word.dest_worker,
							out_word.last);
				end else if (out_word !== due_results[0]) begin
					err_count++;
					if (err_count <= 10)
						$display("exp %0d %h %0d %b, got %0d %h %0d %b",
							due_results[0].kind, due_results[0].dispatch_tag,
							due_results[0].dest_worker, due_results[0].last,
							out_word.kind, out_word.dispatch_tag, out_word.dest_worker,
							out_word.last);
					void'(due_results.pop_front());
				end else begin
					void'(due_results.pop_front());
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: %0d results outstanding", due_results.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (send_q.size() != 0 || in_valid || due_results.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic run_phase(input logic [ACT_W-1:0] act, input logic [BOUND_W-1:0] bnd,
			input int n_words, input int req_pct, input int idle);
		wait_drained();
		write_reg(REG_ACTIVE_WORKERS, CFG_DATA_W'(act));
		write_reg(REG_INITIAL_BOUND, CFG_DATA_W'(bnd));
		idle_pct <= idle;
		for (int k = 0; k < n_words; k++) begin
			do begin
				@(posedge clk);
				#1;
			end while (send_q.size() >= 2);
			send_q.insert(send_q.size(), draw_word(req_pct));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		#1;
		// reset settings: sixteen workers, bound three
		send_q.insert(send_q.size(), word_of(1'b0, 16'h0000, 4'd0, 32'd0, 4'd0));
		send_q.insert(send_q.size(), word_of(1'b0, 16'hFFFF, 4'd0, 32'd0, 4'd0));
		send_q.insert(send_q.size(), word_of(1'b1, 16'h0000, 4'd15, 32'd0, 4'd15));
		wait_drained();
		write_reg(REG_ACTIVE_WORKERS, CFG_DATA_W'(2));
		write_reg(REG_INITIAL_BOUND, CFG_DATA_W'(1));
		@(posedge clk);
		#1;
		// both workers full: tags wait, then one feedback drains them
		send_q.insert(send_q.size(), word_of(1'b0, 16'h1234, 4'd0, 32'd0, 4'd0));
		send_q.insert(send_q.size(), word_of(1'b0, 16'hABCD, 4'd0, 32'd0, 4'd0));
		send_q.insert(send_q.size(), word_of(1'b1, 16'h0000, 4'd5, 32'd0, 4'd3));
		send_q.insert(send_q.size(), word_of(1'b1, 16'h0000, 4'd0, 32'hFFFF_FFFF, 4'd3));
		send_q.insert(send_q.size(), word_of(1'b1, 16'hFFFF, 4'd1, 32'd1, 4'd15));
		send_q.insert(send_q.size(), word_of(1'b1, 16'h0000, 4'd0, 32'd1, 4'd0));
		send_q.insert(send_q.size(), word_of(1'b0, 16'h5555, 4'd15, 32'hFFFF_FFFF, 4'd15));
		send_q.insert(send_q.size(), word_of(1'b1, 16'h0000, 4'd1, 32'd0, 4'd15));
		send_q.insert(send_q.size(), word_of(1'b1, 16'h0000, 4'd1, 32'd3, 4'd0));

		run_phase(5'd3, 4'd1, 80, 85, 7);
		run_phase(5'd16, 4'd15, 60, 50, 7);
		run_phase(5'd0, 4'd0, 50, 70, 7);
		run_phase(5'd31, 4'd15, 60, 30, 7);
		run_phase(5'd1, 4'd0, 50, 60, 7);
		run_phase(5'd16, 4'd3, 60, 55, 0);

		wait_drained();
		repeat (20) @(posedge clk);
		if (err_count == 0 && due_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
